// ----- hw/rtl/ouk_pkg.sv -----
// Shared types and codes for the ordered unique-key table.
package ouk_pkg;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] key;
      logic signed [31:0] amount;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] entry_key;
      logic signed [31:0] entry_amount;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] amount;
   } entry_type;

   localparam logic [1:0] CMD_LIST   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [2:0] STAT_INSERTED  = 3'd0;
   localparam logic [2:0] STAT_DUPLICATE = 3'd1;
   localparam logic [2:0] STAT_REMOVED   = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;
   localparam logic [2:0] STAT_FULL      = 3'd5;
   localparam logic [2:0] STAT_LISTED    = 3'd6;

endpackage

// ----- hw/rtl/ouk_ram.sv -----
// Entry memory: one write port, one registered read port.
module ouk_ram #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  ouk_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output ouk_pkg::entry_type rd_data
);
   import ouk_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ordered_unique_key_table_top.sv -----
// Top level of the ordered unique-key table: sequencer, key compare and output register.
// An empty table answers a list or remove straight from idle; a list streams its entries
//    back to back, insert or remove scans the entries in order, one key compare a cycle,
//    and a hit remove then shifts the entries above the hit down.
// A new command is taken only in idle, once the last one is done; the receiver cannot stall.
// Reset (synchronous, active high) empties the table; memory contents are not cleared.
module ordered_unique_key_table_top #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ouk_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ouk_pkg::rsp_type rsp_data
);
   import ouk_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_LIST  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   req_type       req_ff, req_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   logic          more;
   logic          match;
   logic          full;

   ouk_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // More entries left to fetch; the shared comparator checks the fetched key.
   assign more  = (rd_idx_ff < count_ff);
   assign match = pend_ff && (rd_data.key == req_ff.key);
   assign full  = (count_ff == CW'(DEPTH));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_in.status       = STAT_EMPTY;
      rsp_in.entry_key    = req_ff.key;
      rsp_in.entry_amount = '0;
      rsp_in.last         = 1'b1;
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data.key    = req_ff.key;
      wr_data.amount = req_ff.amount;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in           = req_data;
               rd_idx_in        = '0;
               rsp_in.entry_key = req_data.key;
               unique case (req_data.command)
                  CMD_LIST: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  CMD_INSERT: begin
                     state_in = S_SCAN;
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     // unused command code: drop, no transfer
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Fetch one entry a cycle, compare on the following cycle.
            if (more) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + CW'(1);
            end
            if (match) begin
               pend_in = 1'b0;
               if (req_ff.command == CMD_INSERT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = STAT_DUPLICATE;
                  state_in      = S_IDLE;
               end else begin
                  // Close the gap starting just above the hit.
                  rd_idx_in = CW'(pend_idx_ff) + CW'(1);
                  state_in  = S_SHIFT;
               end
            end else if (!pend_ff && !more) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (req_ff.command == CMD_INSERT) begin
                  if (full) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CW'(1);
                     rsp_in.status = STAT_INSERTED;
                  end
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
         end

         S_SHIFT: begin
            // Read entry i, write it back at i-1 in the following cycle.
            if (more) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + CW'(1);
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - AW'(1);
               wr_data = rd_data;
            end
            if (!pend_ff && !more) begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_in.status = STAT_REMOVED;
               state_in      = S_IDLE;
            end
         end

         S_LIST: begin
            // Stream entries in order, one transfer a cycle.
            if (more) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + CW'(1);
            end
            if (pend_ff) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.status       = STAT_LISTED;
               rsp_in.entry_key    = rd_data.key;
               rsp_in.entry_amount = rd_data.amount;
               rsp_in.last         = (CW'(pend_idx_ff) == count_ff - CW'(1));
               if (rsp_in.last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The entry count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table size");

   // An unused command code produces no transfer.
   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command != CMD_LIST && req_data.command != CMD_INSERT
       && req_data.command != CMD_REMOVE) |=> !rsp_strobe)
      else $error("transfer for unused command");

   // A list streams without gaps up to its last entry.
   a_list_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> (rsp_strobe && rsp_data.status == STAT_LISTED))
      else $error("gap inside list");

   // Shifting only happens with a non-empty table.
   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (count_ff != '0))
      else $error("shift on empty table");

endmodule
